FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk_i and held off by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

FILE: design/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Sizes, codes and the command record shared by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

  // Store geometry; DEPTH must be a power of two (pointers wrap by truncation)
  localparam int unsigned DEPTH     = 256;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);

  // Payload field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned REQ_W  = 7;

  // Compare width for count vs fill, and width of fill + free
  localparam int unsigned CMP_W = (CNT_W > REQ_W) ? CNT_W : REQ_W;
  localparam int unsigned SUM_W = CNT_W + 1;

  // Command queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_READ = 2'd3
  } brf_op_e;

  // What the back end does with a command
  typedef enum logic [1:0] {
    CMD_STATUS = 2'd0,  // single result, no store access
    CMD_PUSH   = 2'd1,  // write one byte, single result
    CMD_RUN    = 2'd2   // read done bytes from addr, one result per byte
  } brf_kind_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_OUT  = 1'b1
  } brf_bk_state_e;

  typedef struct packed {
    brf_kind_e         kind;
    logic [BYTE_W-1:0] data;
    logic [PTR_W-1:0]  addr;
    logic [REQ_W-1:0]  done;
    logic [CNT_W-1:0]  fill;
    logic [CNT_W-1:0]  free;
  } brf_cmd_t;

endpackage

`default_nettype wire

FILE: design/brf_ifs.sv
// ----------------------------------------------------------------------------
// brf_ifs
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface brf_in_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] push_byte;
  logic [REQ_W-1:0]  request_count;

  modport source (output valid, output op, output push_byte, output request_count,
                  input ready);
  modport sink   (input valid, input op, input push_byte, input request_count,
                  output ready);
endinterface

interface brf_out_if import brf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_byte;
  logic              read_valid;
  logic [REQ_W-1:0]  done_count;
  logic [CNT_W-1:0]  fill_level;
  logic [CNT_W-1:0]  free_level;
  logic              run_last;

  modport source (output valid, output read_byte, output read_valid, output done_count,
                  output fill_level, output free_level, output run_last, input ready);
  modport sink   (input valid, input read_byte, input read_valid, input done_count,
                  input fill_level, input free_level, input run_last, output ready);
endinterface

`default_nettype wire

FILE: design/brf_ram.sv
// ----------------------------------------------------------------------------
// brf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: design/brf_front.sv
// ----------------------------------------------------------------------------
// brf_front
// Request decode: owns head, tail and fill count, resolves each request to
// a command with its final levels, and hands it to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module brf_front import brf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  brf_in_if.sink   in_i,
  output brf_cmd_t cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i
);

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0] held_q, held_d;

  brf_op_e          op;
  logic [REQ_W-1:0] req_sat;
  logic [REQ_W-1:0] take;
  logic             room;
  logic             accept;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;

  always_comb begin
    op = brf_op_e'(in_i.op);

    if (in_i.request_count > REQ_W'(MAX_BURST)) begin
      req_sat = REQ_W'(MAX_BURST);
    end else begin
      req_sat = in_i.request_count;
    end

    // bytes actually moved: burst limit, then what is held
    if (CMP_W'(req_sat) < CMP_W'(held_q)) begin
      take = req_sat;
    end else begin
      take = REQ_W'(held_q);
    end

    room = held_q < CNT_W'(DEPTH);

    head_d     = head_q;
    tail_d     = tail_q;
    held_d     = held_q;
    cmd_o.kind = CMD_STATUS;
    cmd_o.data = in_i.push_byte;
    cmd_o.addr = head_q;
    cmd_o.done = take;

    unique case (op)
      OP_PUSH: begin
        if (room) begin
          cmd_o.kind = CMD_PUSH;
          cmd_o.addr = tail_q;
          cmd_o.done = REQ_W'(1);
          tail_d     = tail_q + PTR_W'(1);
          held_d     = held_q + CNT_W'(1);
        end else begin
          cmd_o.done = '0;
        end
      end
      OP_POP: begin
        head_d = head_q + PTR_W'(take);
        held_d = held_q - CNT_W'(take);
      end
      OP_PEEK: begin
        if (take != '0) begin
          cmd_o.kind = CMD_RUN;
        end
      end
      OP_READ: begin
        head_d = head_q + PTR_W'(take);
        held_d = held_q - CNT_W'(take);
        if (take != '0) begin
          cmd_o.kind = CMD_RUN;
        end
      end
      default: begin
        cmd_o.kind = CMD_STATUS;
      end
    endcase

    cmd_o.fill = held_d;
    cmd_o.free = CNT_W'(DEPTH) - held_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      held_q <= '0;
    end else if (accept) begin
      head_q <= head_d;
      tail_q <= tail_d;
      held_q <= held_d;
    end
  end

  `ASSERT_ALWAYS(held_in_range, held_q <= CNT_W'(DEPTH), "fill count above depth")
  `ASSERT_ALWAYS(ptr_gap_matches, tail_q == (head_q + PTR_W'(held_q)), "tail-head gap != fill")

endmodule

`default_nettype wire

FILE: design/brf_queue.sv
// ----------------------------------------------------------------------------
// brf_queue
// Short command FIFO that decouples request decode from result delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_queue import brf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  brf_cmd_t cmd_i,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  output brf_cmd_t cmd_o,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i
);

  brf_cmd_t          slot_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  assign cmd_ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign cmd_valid_o = cnt_q != '0;
  assign cmd_o       = slot_q[rptr_q];
  assign push        = cmd_valid_i && cmd_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = pop ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/brf_back.sv
// ----------------------------------------------------------------------------
// brf_back
// Command execution: writes pushed bytes into the store, streams read runs
// one byte per beat, and drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module brf_back import brf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  brf_cmd_t  cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  brf_out_if.source out_o
);

  brf_bk_state_e     state_q, state_d;
  brf_cmd_t          cur_q;
  logic [REQ_W-1:0]  rem_q;
  logic [PTR_W-1:0]  addr_q;

  logic              fire;
  logic              last;
  logic              load;
  logic              is_run;

  logic              wr_en;
  logic              rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  logic [SUM_W-1:0]  lvl_sum;

  assign is_run = cur_q.kind == CMD_RUN;
  assign last   = !is_run || (rem_q == REQ_W'(1));
  assign fire   = out_o.valid && out_o.ready;
  // next command is taken when idle or as the final beat of the current one leaves
  assign load   = cmd_valid_i && ((state_q == BK_IDLE) || (fire && last));
  assign cmd_ready_o = load;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (load) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (fire && last && !load) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs and store control
  always_comb begin
    out_o.valid      = state_q == BK_OUT;
    out_o.read_valid = is_run;
    out_o.read_byte  = is_run ? rd_data : '0;
    out_o.done_count = cur_q.done;
    out_o.fill_level = cur_q.fill;
    out_o.free_level = cur_q.free;
    out_o.run_last   = last;

    wr_en   = load && (cmd_i.kind == CMD_PUSH);
    // fire && !last never coincides with load
    rd_en   = (load && (cmd_i.kind == CMD_RUN)) || (fire && !last);
    rd_addr = load ? cmd_i.addr : addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q  <= cmd_i;
      rem_q  <= cmd_i.done;
      addr_q <= cmd_i.addr + PTR_W'(1);
    end else if (fire && !last) begin
      rem_q  <= rem_q - REQ_W'(1);
      addr_q <= addr_q + PTR_W'(1);
    end
  end

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cmd_i.addr),
    .wr_data_i (cmd_i.data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign lvl_sum = SUM_W'(cur_q.fill) + SUM_W'(cur_q.free);

  `ASSERT_IMPLIES(run_has_bytes, (state_q == BK_OUT) && is_run, rem_q != '0, "empty run beat")
  `ASSERT_IMPLIES(levels_add_up, out_o.valid, lvl_sum == SUM_W'(DEPTH), "fill + free != depth")

endmodule

`default_nettype wire

FILE: design/byte_ring_fifo_bulk.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_bulk
// Circular byte FIFO with push, pop, peek and read-and-pop requests.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      beat
//   in_i     in   valid/ready    op, push_byte, request_count
//   out_o    out  valid/ready    read_byte, read_valid, done_count,
//                                fill_level, free_level, run_last
//
// Push, pop and empty runs give one result beat each; a read run of n bytes
// gives n beats, one per cycle while out_o is ready, set by the single read
// port of the store. Sustained rate is one request per cycle for single-beat
// requests while out_o is ready; requests pass a queue slot, then cur_q.
// A four-entry command queue lets requests keep coming while results stall.
// Reset clears pointers and counts at once; no clearing pass of the store.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_bulk import brf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  brf_in_if.sink    in_i,
  brf_out_if.source out_o
);

  brf_cmd_t front_cmd;
  logic     front_valid;
  logic     front_ready;
  brf_cmd_t back_cmd;
  logic     back_valid;
  logic     back_ready;

  brf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  brf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (front_cmd),
    .cmd_valid_i (front_valid),
    .cmd_ready_o (front_ready),
    .cmd_o       (back_cmd),
    .cmd_valid_o (back_valid),
    .cmd_ready_i (back_ready)
  );

  brf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

FILE: tb/byte_ring_fifo_bulk_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_bulk_test
// Self-checking bench for the byte ring FIFO. It runs a short directed table
// and then randomized request traffic. A mirror of the ring predicts every
// result beat, and each beat taken from the output is compared with the
// oldest expected beat. Both channels idle at random, and one long receiver
// stall backs the block up until it stalls its input.
// ----------------------------------------------------------------------------

module byte_ring_fifo_bulk_test;
  import brf_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              read_valid;
    logic [REQ_W-1:0]  done_count;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_level;
    logic              run_last;
  } beat_t;

  typedef struct packed {
    brf_op_e           op;
    logic [BYTE_W-1:0] data;
    logic [REQ_W-1:0]  count;
    logic              typed;   // exp is spelled out below, else predicted
    beat_t             exp;
  } stim_row_t;

  localparam int unsigned N_ROWS    = 17;
  localparam int unsigned LONG_HOLD = 300;

  logic clk_i;
  logic rst_ni;

  brf_in_if  in_ch ();
  brf_out_if out_ch ();

  byte_ring_fifo_bulk DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Directed requests; fill level returns to zero at the end
  stim_row_t directed_rows [N_ROWS] = '{
    '{OP_POP,  8'h00, 7'd5,   1'b1, '{8'h00, 1'b0, 7'd0, 9'd0, 9'd256, 1'b1}},
    '{OP_PEEK, 8'h00, 7'd10,  1'b1, '{8'h00, 1'b0, 7'd0, 9'd0, 9'd256, 1'b1}},
    '{OP_READ, 8'h00, 7'd64,  1'b1, '{8'h00, 1'b0, 7'd0, 9'd0, 9'd256, 1'b1}},
    '{OP_PUSH, 8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 7'd1, 9'd1, 9'd255, 1'b1}},
    '{OP_PUSH, 8'hFF, 7'd127, 1'b1, '{8'h00, 1'b0, 7'd1, 9'd2, 9'd254, 1'b1}},
    '{OP_PUSH, 8'hA5, 7'd0,   1'b1, '{8'h00, 1'b0, 7'd1, 9'd3, 9'd253, 1'b1}},
    '{OP_PUSH, 8'h5A, 7'd64,  1'b1, '{8'h00, 1'b0, 7'd1, 9'd4, 9'd252, 1'b1}},
    '{OP_PEEK, 8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 7'd0, 9'd4, 9'd252, 1'b1}},
    '{OP_PEEK, 8'h00, 7'd2,   1'b0, '0},
    '{OP_PEEK, 8'h00, 7'd127, 1'b0, '0},
    '{OP_READ, 8'h00, 7'd1,   1'b0, '0},
    '{OP_POP,  8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 7'd0, 9'd3, 9'd253, 1'b1}},
    '{OP_READ, 8'h00, 7'd2,   1'b0, '0},
    '{OP_POP,  8'h00, 7'd127, 1'b1, '{8'h00, 1'b0, 7'd1, 9'd0, 9'd256, 1'b1}},
    '{OP_READ, 8'h00, 7'd0,   1'b1, '{8'h00, 1'b0, 7'd0, 9'd0, 9'd256, 1'b1}},
    '{OP_PUSH, 8'h3C, 7'd0,   1'b1, '{8'h00, 1'b0, 7'd1, 9'd1, 9'd255, 1'b1}},
    '{OP_READ, 8'h00, 7'd100, 1'b0, '0}
  };

  // Mirror of the ring
  logic [BYTE_W-1:0] mirror_mem [DEPTH];
  logic [PTR_W-1:0]  mirror_head;
  logic [PTR_W-1:0]  mirror_tail;
  int unsigned       mirror_fill;

  beat_t expected_beats [$];
  beat_t typed_beats [int];

  int  items_sent;
  int  items_taken;
  int  fail_count;
  bit  src_idle;
  bit  sink_idle;
  int  hold_request;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("byte_ring_fifo_bulk verification failed");
    $finish;
  end

  // Apply one request to the mirror; record the beats it should produce
  function automatic void mirror_request(brf_op_e op, logic [BYTE_W-1:0] data,
                                         logic [REQ_W-1:0] count, bit record);
    int unsigned take;
    int unsigned burst;
    logic [PTR_W-1:0] start;
    beat_t b;
    b = '0;
    b.run_last = 1'b1;
    if (op == OP_PUSH) begin
      if (mirror_fill < DEPTH) begin
        mirror_mem[mirror_tail] = data;
        mirror_tail = mirror_tail + PTR_W'(1);
        mirror_fill++;
        b.done_count = 7'd1;
      end
      b.fill_level = CNT_W'(mirror_fill);
      b.free_level = CNT_W'(DEPTH - mirror_fill);
      if (record) expected_beats.push_back(b);
      return;
    end
    burst = (count > MAX_BURST) ? MAX_BURST : count;
    take  = (burst < mirror_fill) ? burst : mirror_fill;
    start = mirror_head;
    if (op != OP_PEEK) begin
      mirror_head = mirror_head + PTR_W'(take);
      mirror_fill -= take;
    end
    b.done_count = REQ_W'(take);
    b.fill_level = CNT_W'(mirror_fill);
    b.free_level = CNT_W'(DEPTH - mirror_fill);
    if (op == OP_POP || take == 0) begin
      if (record) expected_beats.push_back(b);
      return;
    end
    for (int unsigned i = 0; i < take; i++) begin
      b.read_byte  = mirror_mem[PTR_W'(start + i)];
      b.read_valid = 1'b1;
      b.run_last   = (i + 1 == take);
      if (record) expected_beats.push_back(b);
    end
  endfunction

  task automatic log_failure(string what, beat_t want, beat_t seen);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: exp byte %02h vld %0d done %0d fill %0d free %0d last %0d",
               $realtime, what, want.read_byte, want.read_valid, want.done_count,
               want.fill_level, want.free_level, want.run_last);
      $display("    got byte %02h vld %0d done %0d fill %0d free %0d last %0d",
               seen.read_byte, seen.read_valid, seen.done_count, seen.fill_level,
               seen.free_level, seen.run_last);
    end
  endtask

  // Request and result monitor
  always @(posedge clk_i) begin : watch
    beat_t seen;
    beat_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        if (typed_beats.exists(items_taken)) begin
          mirror_request(brf_op_e'(in_ch.op), in_ch.push_byte, in_ch.request_count, 1'b0);
          expected_beats.push_back(typed_beats[items_taken]);
          typed_beats.delete(items_taken);
        end else begin
          mirror_request(brf_op_e'(in_ch.op), in_ch.push_byte, in_ch.request_count, 1'b1);
        end
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        seen.read_byte  = out_ch.read_byte;
        seen.read_valid = out_ch.read_valid;
        seen.done_count = out_ch.done_count;
        seen.fill_level = out_ch.fill_level;
        seen.free_level = out_ch.free_level;
        seen.run_last   = out_ch.run_last;
        if (expected_beats.size() == 0) begin
          log_failure("unexpected beat", '0, seen);
        end else begin
          want = expected_beats.pop_front();
          if (seen.read_byte  !== want.read_byte  || seen.read_valid !== want.read_valid ||
              seen.done_count !== want.done_count || seen.fill_level !== want.fill_level ||
              seen.free_level !== want.free_level || seen.run_last   !== want.run_last)
            log_failure("mismatch", want, seen);
        end
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // Result side: random stalls plus the long hold on request
  initial begin : sink_side
    int unsigned stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = gap_cycles() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic offer_request(brf_op_e op, logic [BYTE_W-1:0] data,
                               logic [REQ_W-1:0] count);
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.push_byte     <= data;
    in_ch.request_count <= count;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (src_idle && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_cycles()) @(posedge clk_i);
    end
  endtask

  task automatic offer_random();
    brf_op_e op;
    int unsigned push_pct;
    int unsigned roll;
    logic [REQ_W-1:0] count;
    push_pct = (mirror_fill < 32) ? 70 : ((mirror_fill > 200) ? 25 : 50);
    op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : brf_op_e'($urandom_range(1, 3));
    roll = $urandom_range(0, 9);
    if (roll < 6)      count = REQ_W'($urandom_range(0, 16));
    else if (roll < 9) count = REQ_W'($urandom_range(17, 64));
    else               count = REQ_W'($urandom_range(65, 127));
    offer_request(op, BYTE_W'($urandom_range(0, 255)), count);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (expected_beats.size() != 0);
  endtask

  initial begin : source_side
    mirror_head  = '0;
    mirror_tail  = '0;
    mirror_fill  = 0;
    items_sent   = 0;
    items_taken  = 0;
    fail_count   = 0;
    hold_request = 0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    rst_ni              <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_PUSH;
    in_ch.push_byte     <= '0;
    in_ch.request_count <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) typed_beats[items_sent] = directed_rows[i].exp;
      offer_request(directed_rows[i].op, directed_rows[i].data, directed_rows[i].count);
    end

    // Receiver holds off while pushes keep coming; the block backs up and stalls
    src_idle     = 1'b0;
    hold_request = LONG_HOLD;
    repeat (24) offer_request(OP_PUSH, BYTE_W'($urandom_range(0, 255)), 7'd0);
    offer_request(OP_PEEK, 8'h00, 7'd127);
    repeat (3) offer_request(OP_READ, 8'h00, 7'd64);
    offer_request(OP_POP, 8'h00, 7'd100);
    offer_request(OP_READ, 8'h00, 7'd64);
    in_ch.valid <= 1'b0;
    wait_drained();

    for (int seg = 0; seg < 4; seg++) begin
      src_idle  = (seg == 0 || seg == 2);
      sink_idle = (seg == 0 || seg == 3);
      repeat (21) offer_random();
    end
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("byte_ring_fifo_bulk verification clean");
    end else begin
      $display("byte_ring_fifo_bulk verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/brf_pkg.sv
design/brf_ifs.sv
design/brf_ram.sv
design/brf_front.sv
design/brf_queue.sv
design/brf_back.sv
design/byte_ring_fifo_bulk.sv
tb/byte_ring_fifo_bulk_test.sv
